### sv/pwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwt_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 8;
    localparam int STAMP_W         = 32;
    localparam int SCALE_W         = 32;
    localparam int RPM_W           = 32;
    localparam int PULSES_W        = 8;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd30000000;

    // input event codes
    localparam logic ACT_PULSE      = 1'b0;
    localparam logic ACT_WINDOW_END = 1'b1;

    typedef struct packed {
        logic               action;
        logic [STAMP_W-1:0] timestamp_us;
    } in_word_t;

    typedef struct packed {
        logic [RPM_W-1:0]    rpm;
        logic [PULSES_W-1:0] pulses_in_window;
        logic                span_zero;
    } out_word_t;

    typedef struct packed {
        logic pulse;
        logic start;
        logic step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/pwt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pwt_ctrl
    import pwt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_action,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.pulse    = 1'b0;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.pulse = accept && (in_action == ACT_PULSE);
                cmd.start = accept && (in_action == ACT_WINDOW_END);
                if (cmd.start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output word is free
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### sv/pwt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pwt_datapath
    import pwt_pkg::*;
#(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [SCALE_W-1:0] cfg_wr_data,
    input  wire in_word_t           in_data,
    input  wire ctrl_cmd_t          cmd,
    output dp_status_t              status,
    output out_word_t               out_data
);

    localparam int NUM_W  = SCALE_W + COUNT_WIDTH;
    localparam int STEP_W = $clog2(NUM_W);

    logic [SCALE_W-1:0]     scale_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [TIME_WIDTH-1:0]  span_reg;
    logic [TIME_WIDTH-1:0]  span_next;
    logic [TIME_WIDTH-1:0]  mark_reg;
    logic [TIME_WIDTH-1:0]  mark_next;

    logic [NUM_W-1:0]       quo_reg;
    logic [NUM_W-1:0]       quo_next;
    logic [TIME_WIDTH-1:0]  rem_reg;
    logic [TIME_WIDTH-1:0]  rem_next;
    logic [TIME_WIDTH-1:0]  divisor_reg;
    logic                   zero_reg;
    logic [PULSES_W-1:0]    pulses_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;
    out_word_t              out_reg;
    out_word_t              out_next;

    logic [TIME_WIDTH-1:0]  now;
    logic [TIME_WIDTH-1:0]  delta;
    logic [TIME_WIDTH:0]    span_sum;
    logic [NUM_W-1:0]       product;
    logic [TIME_WIDTH:0]    trial;
    logic                   fits;

    assign now      = TIME_WIDTH'(in_data.timestamp_us);
    assign delta    = now - mark_reg;
    assign span_sum = {1'b0, span_reg} + {1'b0, delta};
    assign product  = NUM_W'(scale_reg) * NUM_W'(count_reg);

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    assign status.div_last = (step_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        span_next  = span_reg;
        mark_next  = mark_reg;
        if (cmd.pulse)
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
            span_next  = span_sum[TIME_WIDTH] ? '1 : span_sum[TIME_WIDTH-1:0];
            mark_next  = now;
        end
        else if (cmd.start)
        begin
            count_next = '0;
            span_next  = '0;
            mark_next  = now;
        end
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (cmd.start)
        begin
            quo_next  = product;
            rem_next  = '0;
            step_next = STEP_W'(NUM_W - 1);
        end
        else if (cmd.step)
        begin
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            rem_next  = fits ? TIME_WIDTH'(trial - {1'b0, divisor_reg})
                             : trial[TIME_WIDTH-1:0];
            step_next = step_reg - STEP_W'(1);
        end
    end

    always_comb
    begin
        out_next                  = out_reg;
        out_next.pulses_in_window = pulses_reg;
        out_next.span_zero        = zero_reg;
        priority if (zero_reg)
        begin
            out_next.rpm = '0;
        end
        else if (|quo_reg[NUM_W-1:RPM_W])
        begin
            out_next.rpm = '1;
        end
        else
        begin
            out_next.rpm = quo_reg[RPM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            count_reg <= '0;
            span_reg  <= '0;
            mark_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            span_reg  <= span_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        if (cmd.start)
        begin
            divisor_reg <= span_reg;
            zero_reg    <= (span_reg == '0);
            pulses_reg  <= count_reg[PULSES_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

### sv/pulse_window_tachometer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Pulse-rate tachometer over measurement windows. Each input word carries an
// action and a free-running microsecond timestamp. A pulse word counts one
// sensor edge and adds the time since the last mark to the window span. A
// window-end word reports floor(rpm_scale * count / span) saturated to 32
// bits (0 with span_zero set when the span is empty), then restarts the window
// at its own timestamp. The report comes from a bit-serial restoring divider
// over the 32 + COUNT_WIDTH bit product, so a window end stalls the input
// until the divide is done and the result is loaded into the output word,
// plus any time the previous result still waits on the output. rpm_scale
// resets to 30000000; the user must write it through cfg_wr_en / cfg_wr_data
// only while the block is idle, and the block itself does not enforce this.
module pulse_window_tachometer_core
    import pwt_pkg::*;
#(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [SCALE_W-1:0] cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire in_word_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_word_t               out_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    pwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pwt_datapath #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .status      (status),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire
